### src/swq_pkg.sv
// Shared types and constants for the skin weight byte quantizer.
`default_nettype none

package swq_pkg;

  localparam int SLOTS       = 4;
  localparam int WEIGHT_BITS = 24;
  localparam int SLOT_CNT_W  = 3;
  localparam int BYTE_W      = 8;
  localparam int FRAC_BITS   = 16;
  localparam int FULL_SCALE  = 255;
  localparam int EPS_Q16     = 66;

  // Quotient bits: 255 * 2^16 fits below 2^QB.
  localparam int QB       = BYTE_W + FRAC_BITS;
  localparam int SLOT_W   = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
  localparam int SUM_W    = WEIGHT_BITS + SLOT_W;
  localparam int DIV_W    = SUM_W - 1;
  localparam int PROD_W   = WEIGHT_BITS + 7;
  localparam int REM_W    = FRAC_BITS + SLOT_W + 3;
  localparam int ASSIGN_W = BYTE_W + SLOT_W + 1;

  localparam logic [QB-1:0] Q_MAX = QB'(FULL_SCALE) << FRAC_BITS;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_0;
    logic signed [WEIGHT_BITS-1:0] weight_1;
    logic signed [WEIGHT_BITS-1:0] weight_2;
    logic signed [WEIGHT_BITS-1:0] weight_3;
    logic [SLOT_CNT_W-1:0]         slot_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_0;
    logic [BYTE_W-1:0] byte_1;
    logic [BYTE_W-1:0] byte_2;
    logic [BYTE_W-1:0] byte_3;
  } out_item_t;

  // One divider stage: partial remainders, pending dividend bits, quotients.
  typedef struct packed {
    logic [SLOTS-1:0]             used;
    logic                         active;
    logic [DIV_W-1:0]             divisor;
    logic [SLOTS-1:0][DIV_W-1:0]  prem;
    logic [SLOTS-1:0][QB-1:0]     low;
    logic [SLOTS-1:0][QB-1:0]     quot;
    logic [SLOTS-1:0]             sat;
  } div_state_t;

  // One award stage: bytes, remainders and running total.
  typedef struct packed {
    logic [SLOTS-1:0]              used;
    logic [SLOTS-1:0][BYTE_W-1:0]  bytes;
    logic [SLOTS-1:0][REM_W-1:0]   rem;
    logic [ASSIGN_W-1:0]           assigned;
    logic                          done;
  } dist_state_t;

endpackage

`default_nettype wire

### src/swq_div_stage.sv
// One restoring division step for all slot lanes, registered.
`default_nettype none

module swq_div_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               valid_in,
  input  wire swq_pkg::div_state_t d_in,
  output logic                    valid_r,
  output swq_pkg::div_state_t     d_r
);
  import swq_pkg::*;

  div_state_t d_nxt;

  // Shift in one dividend bit per lane, subtract divisor when it fits
  always_comb begin
    logic [DIV_W:0] sh;
    logic           ge;
    d_nxt = d_in;
    for (int k = 0; k < SLOTS; k++) begin
      sh = {d_in.prem[k], d_in.low[k][QB-1]};
      ge = sh >= {1'b0, d_in.divisor};
      d_nxt.prem[k] = ge ? DIV_W'(sh - {1'b0, d_in.divisor}) : sh[DIV_W-1:0];
      d_nxt.low[k]  = d_in.low[k] << 1;
      d_nxt.quot[k] = {d_in.quot[k][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
    if (adv) begin
      d_r <= d_nxt;
    end
  end

endmodule

`default_nettype wire

### src/swq_award_stage.sv
// One unit of the shortfall to the largest remainder, registered.
`default_nettype none

module swq_award_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                valid_in,
  input  wire swq_pkg::dist_state_t s_in,
  output logic                     valid_r,
  output swq_pkg::dist_state_t     s_r
);
  import swq_pkg::*;

  dist_state_t s_nxt;

  always_comb begin
    logic [SLOT_W-1:0] best;
    best  = '0;
    s_nxt = s_in;
    // Pick the largest remainder among used slots, lower slot on ties
    for (int k = 1; k < SLOTS; k++) begin
      if (s_in.used[k] && ($signed(s_in.rem[k]) > $signed(s_in.rem[best]))) begin
        best = SLOT_W'(k);
      end
    end
    // Award one unit, or stop when the chosen byte is full
    if (!s_in.done && (s_in.assigned < ASSIGN_W'(FULL_SCALE))) begin
      if (s_in.bytes[best] >= BYTE_W'(FULL_SCALE)) begin
        s_nxt.done = 1'b1;
      end else begin
        s_nxt.bytes[best] = s_in.bytes[best] + 1'b1;
        s_nxt.rem[best]   = s_in.rem[best] - (REM_W'(1) << FRAC_BITS);
        s_nxt.assigned    = s_in.assigned + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
    if (adv) begin
      s_r <= s_nxt;
    end
  end

endmodule

`default_nettype wire

### src/skin_weight_byte_quantizer_top.sv
// Top level of the skin weight byte quantizer pipeline.
//
// Splits 255 over up to four blend slots by largest remainder.
// Input channel in_valid/in_ready/in_data carries four signed Q7.16
// weights and a slot count (values above 4 act as 4). Result channel
// out_valid/out_ready/out_data carries four bytes; unused slots give 0,
// and a zero count or non-positive weight sum gives all zeros.
// The pipeline has one input stage (sum and 255*w), 24 restoring
// division stages (one quotient bit each, all slots in parallel), one
// rounding stage and four award stages, the last of which is the output
// register. One item can be taken every cycle unless the output stalls.
// The whole pipeline advances together: when out_valid is high and
// out_ready is low, every stage holds and in_ready drops, so nothing is
// lost or repeated. Reset (rst_n low, synchronous) clears all valid bits;
// the block holds no other state.
`default_nettype none

module skin_weight_byte_quantizer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire swq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output swq_pkg::out_item_t      out_data
);
  import swq_pkg::*;

  logic adv;

  logic        div_vld [QB+1];
  div_state_t  div_st  [QB+1];
  logic        dst_vld [SLOTS+1];
  dist_state_t dst_st  [SLOTS+1];

  div_state_t  d0_nxt;
  dist_state_t r_nxt;

  // Advance every stage when the output register is free or drained
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Sum used weights, scale positives by 255, set up the divider
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w [SLOTS];
    logic [SLOT_CNT_W-1:0]         n;
    logic signed [SUM_W-1:0]       sum;
    logic [WEIGHT_BITS-2:0]        pos;
    logic [PROD_W-1:0]             prod;
    logic [DIV_W-1:0]              r0;
    w[0] = in_data.weight_0;
    w[1] = in_data.weight_1;
    w[2] = in_data.weight_2;
    w[3] = in_data.weight_3;
    n    = (in_data.slot_count > SLOT_CNT_W'(SLOTS)) ? SLOT_CNT_W'(SLOTS)
                                                     : in_data.slot_count;
    sum  = '0;
    d0_nxt = '0;
    for (int k = 0; k < SLOTS; k++) begin
      d0_nxt.used[k] = SLOT_CNT_W'(k) < n;
      if (d0_nxt.used[k]) begin
        sum = sum + SUM_W'(w[k]);
      end
    end
    d0_nxt.active  = (n != '0) && (sum > 0);
    d0_nxt.divisor = sum[DIV_W-1:0];
    for (int k = 0; k < SLOTS; k++) begin
      pos  = (w[k] > 0) ? w[k][WEIGHT_BITS-2:0] : '0;
      prod = {pos, 8'b0} - PROD_W'(pos);
      r0   = DIV_W'(prod[PROD_W-1:8]);
      d0_nxt.prem[k] = r0;
      d0_nxt.low[k]  = {prod[7:0], {FRAC_BITS{1'b0}}};
      d0_nxt.quot[k] = '0;
      d0_nxt.sat[k]  = r0 >= sum[DIV_W-1:0];
    end
  end

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld[0] <= 1'b0;
    end else if (adv) begin
      div_vld[0] <= in_valid;
    end
    if (adv) begin
      div_st[0] <= d0_nxt;
    end
  end

  // Division pipeline, one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    swq_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .valid_in (div_vld[i]),
      .d_in     (div_st[i]),
      .valid_r  (div_vld[i+1]),
      .d_r      (div_st[i+1])
    );
  end

  // Saturate, floor with epsilon and keep the remainder
  always_comb begin
    logic [QB-1:0]     q;
    logic [QB:0]       qe;
    logic [BYTE_W-1:0] b;
    r_nxt          = '0;
    r_nxt.used     = div_st[QB].used;
    r_nxt.done     = !div_st[QB].active;
    for (int k = 0; k < SLOTS; k++) begin
      q  = (div_st[QB].sat[k] || (div_st[QB].quot[k] > Q_MAX)) ? Q_MAX
                                                               : div_st[QB].quot[k];
      qe = {1'b0, q} + (QB+1)'(EPS_Q16);
      b  = qe[QB-1:FRAC_BITS];
      if (div_st[QB].active && div_st[QB].used[k]) begin
        r_nxt.bytes[k]  = b;
        r_nxt.rem[k]    = REM_W'(q) - (REM_W'(b) << FRAC_BITS);
        r_nxt.assigned  = r_nxt.assigned + ASSIGN_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_vld[0] <= 1'b0;
    end else if (adv) begin
      dst_vld[0] <= div_vld[QB];
    end
    if (adv) begin
      dst_st[0] <= r_nxt;
    end
  end

  // Award chain, one unit of shortfall per stage
  for (genvar i = 0; i < SLOTS; i++) begin : g_award
    swq_award_stage u_award (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .valid_in (dst_vld[i]),
      .s_in     (dst_st[i]),
      .valid_r  (dst_vld[i+1]),
      .s_r      (dst_st[i+1])
    );
  end

  // Drive the result from the last award stage
  assign out_valid       = dst_vld[SLOTS];
  assign out_data.byte_0 = dst_st[SLOTS].bytes[0];
  assign out_data.byte_1 = dst_st[SLOTS].bytes[1];
  assign out_data.byte_2 = dst_st[SLOTS].bytes[2];
  assign out_data.byte_3 = dst_st[SLOTS].bytes[3];

  // Unused slots never carry a nonzero byte
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((dst_st[SLOTS].used[1] || dst_st[SLOTS].bytes[1] == '0) &&
                   (dst_st[SLOTS].used[2] || dst_st[SLOTS].bytes[2] == '0) &&
                   (dst_st[SLOTS].used[3] || dst_st[SLOTS].bytes[3] == '0)))
    else $error("unused slot carries a nonzero byte");

  // The award chain is long enough to close every shortfall
  a_dist_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (dst_st[SLOTS].done ||
                   dst_st[SLOTS].assigned >= ASSIGN_W'(FULL_SCALE)))
    else $error("shortfall left after last award stage");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
